[design/rau_pkg.sv]
package rau_pkg;

  localparam int unsigned CMD_BITS     = 2;
  localparam int unsigned RES_NUM_BITS = 33;
  localparam int unsigned RES_DEN_BITS = 31;
  localparam int unsigned STATUS_BITS  = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ZERO_DEN = 2'd1,
    STATUS_DIV_ZERO = 2'd2
  } status_e;

  // which cross product the shared multiplier forms
  typedef enum logic [1:0] {
    MUL_T1  = 2'd0,
    MUL_T2  = 2'd1,
    MUL_DEN = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     sum;
    logic     fix;
    logic     gcd_init;
    logic     gcd_step;
    logic     g_load;
    logic     div_start;
    logic     div_den;
    logic     q_load;
    logic     out_load;
  } ctl_t;

  typedef struct packed {
    status_e err;
    logic    gcd_done;
    logic    div_done;
  } sts_t;

endpackage

[design/rau_div.sv]
module rau_div #(
  parameter int unsigned WIDTH = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic             busy_q;
  logic [CW-1:0]    cnt_q;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] dvs_q;
  logic [WIDTH:0]   shifted;
  logic [WIDTH+1:0] trial;
  logic             fits;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = ~trial[WIDTH+1];
  assign rem_d   = fits ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
  assign quo_d   = {quo_q[WIDTH-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(WIDTH);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != CW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = ~busy_q;
  assign quotient_o = quo_q;

endmodule

[design/rau_dp.sv]
module rau_dp #(
  parameter int unsigned OPERAND_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rau_pkg::ctl_t                      ctl_i,
  input  logic [rau_pkg::CMD_BITS-1:0]       cmd_i,
  input  logic [OPERAND_BITS-1:0]            a_num_i,
  input  logic [OPERAND_BITS-1:0]            a_den_i,
  input  logic [OPERAND_BITS-1:0]            b_num_i,
  input  logic [OPERAND_BITS-1:0]            b_den_i,
  output rau_pkg::sts_t                      sts_o,
  output logic [rau_pkg::RES_NUM_BITS-1:0]   res_num_o,
  output logic [rau_pkg::RES_DEN_BITS-1:0]   res_den_o,
  output logic [rau_pkg::STATUS_BITS-1:0]    status_o
);

  localparam int unsigned OB = OPERAND_BITS;
  localparam int unsigned MW = 2 * OB;
  localparam int unsigned W  = MW + 1;
  localparam int unsigned KW = $clog2(W + 1);
  localparam int unsigned XN = (W > rau_pkg::RES_NUM_BITS) ? W : rau_pkg::RES_NUM_BITS;
  localparam int unsigned XD = (W > rau_pkg::RES_DEN_BITS) ? W : rau_pkg::RES_DEN_BITS;

  // operand magnitudes and signs
  logic [OB-1:0] an_m, ad_m, bn_m, bd_m;
  logic [OB-1:0] an_m_q, ad_m_q, bn_m_q, bd_m_q;
  logic          an_s_q, ad_s_q, bn_s_q, bd_s_q;
  rau_pkg::cmd_e    op_q;
  rau_pkg::status_e err_d, err_q;

  assign an_m = a_num_i[OB-1] ? (~a_num_i + 1'b1) : a_num_i;
  assign ad_m = a_den_i[OB-1] ? (~a_den_i + 1'b1) : a_den_i;
  assign bn_m = b_num_i[OB-1] ? (~b_num_i + 1'b1) : b_num_i;
  assign bd_m = b_den_i[OB-1] ? (~b_den_i + 1'b1) : b_den_i;

  always_comb begin
    if (a_den_i == '0 || b_den_i == '0) begin
      err_d = rau_pkg::STATUS_ZERO_DEN;
    end else if (rau_pkg::cmd_e'(cmd_i) == rau_pkg::CMD_DIV && b_num_i == '0) begin
      err_d = rau_pkg::STATUS_DIV_ZERO;
    end else begin
      err_d = rau_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      op_q   <= rau_pkg::cmd_e'(cmd_i);
      err_q  <= err_d;
      an_m_q <= an_m;
      ad_m_q <= ad_m;
      bn_m_q <= bn_m;
      bd_m_q <= bd_m;
      an_s_q <= a_num_i[OB-1];
      ad_s_q <= a_den_i[OB-1];
      bn_s_q <= b_num_i[OB-1];
      bd_s_q <= b_den_i[OB-1];
    end
  end

  // shared multiplier
  logic [OB-1:0] mx, my;
  logic          sx, sy;
  logic [MW-1:0] prod;
  logic [MW-1:0] t1_q, t2_q, den_q;
  logic          t1_neg_q, t2_neg_q, den_neg_q;

  always_comb begin
    mx = an_m_q;
    sx = an_s_q;
    my = bd_m_q;
    sy = bd_s_q;
    case (ctl_i.mul_sel)
      rau_pkg::MUL_T1: begin
        if (op_q == rau_pkg::CMD_MUL) begin
          my = bn_m_q;
          sy = bn_s_q;
        end
      end
      rau_pkg::MUL_T2: begin
        mx = bn_m_q;
        sx = bn_s_q;
        my = ad_m_q;
        sy = ad_s_q;
      end
      rau_pkg::MUL_DEN: begin
        mx = ad_m_q;
        sx = ad_s_q;
        if (op_q == rau_pkg::CMD_DIV) begin
          my = bn_m_q;
          sy = bn_s_q;
        end
      end
      default: begin
        mx = an_m_q;
        sx = an_s_q;
      end
    endcase
  end

  assign prod = MW'(mx) * MW'(my);

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      case (ctl_i.mul_sel)
        rau_pkg::MUL_T1: begin
          t1_q     <= prod;
          t1_neg_q <= sx ^ sy;
        end
        rau_pkg::MUL_T2: begin
          t2_q     <= prod;
          t2_neg_q <= sx ^ sy;
        end
        rau_pkg::MUL_DEN: begin
          den_q     <= prod;
          den_neg_q <= sx ^ sy;
        end
        default: begin
          t1_q     <= prod;
          t1_neg_q <= sx ^ sy;
        end
      endcase
    end
  end

  // sign-magnitude add: one adder, then a fixup step that negates a negative difference
  logic         is_as, q_neg, mixed;
  logic [W:0]   t1x, t2x, addend, acc_d, acc_q, acc_neg;
  logic         mixed_q, q_neg_q;
  logic [W-1:0] num_mag_q;
  logic         num_neg_q;

  assign is_as  = (op_q == rau_pkg::CMD_ADD) || (op_q == rau_pkg::CMD_SUB);
  assign q_neg  = t2_neg_q ^ (op_q == rau_pkg::CMD_SUB);
  assign mixed  = is_as && (t1_neg_q != q_neg);
  assign t1x    = (W+1)'(t1_q);
  assign t2x    = (W+1)'(t2_q);
  assign addend = !is_as ? '0 : (mixed ? ~t2x : t2x);
  assign acc_d  = t1x + addend + (W+1)'(mixed);
  assign acc_neg = ~acc_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (ctl_i.sum) begin
      acc_q   <= acc_d;
      mixed_q <= mixed;
      q_neg_q <= q_neg;
    end
    if (ctl_i.fix) begin
      if (mixed_q && acc_q[W]) begin
        num_mag_q <= acc_neg[W-1:0];
        num_neg_q <= q_neg_q;
      end else begin
        num_mag_q <= acc_q[W-1:0];
        num_neg_q <= t1_neg_q;
      end
    end
  end

  // binary gcd, one shift, swap or subtract per cycle
  logic [W-1:0]  u_q, v_q, g_q;
  logic [KW-1:0] k_q;
  logic [W:0]    diff;

  assign diff = {1'b0, u_q} - {1'b0, v_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.gcd_init) begin
      u_q <= num_mag_q;
      v_q <= W'(den_q);
      k_q <= '0;
    end else if (ctl_i.gcd_step) begin
      if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (diff[W]) begin
        u_q <= v_q;
        v_q <= u_q;
      end else begin
        u_q <= diff[W-1:0] >> 1;
      end
    end
    if (ctl_i.g_load) begin
      g_q <= v_q << k_q;
    end
  end

  // exact divisions by the gcd
  logic [W-1:0] quotient;
  logic [W-1:0] nm_q, dm_q;
  logic         div_done;

  rau_div #(
    .WIDTH(W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl_i.div_start),
    .dividend_i (ctl_i.div_den ? W'(den_q) : num_mag_q),
    .divisor_i  (g_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.q_load) begin
      if (ctl_i.div_den) begin
        dm_q <= quotient;
      end else begin
        nm_q <= quotient;
      end
    end
  end

  // result register
  logic          res_neg;
  logic [XN-1:0] nm_x, num_val;
  logic [XD-1:0] dm_x;
  logic [rau_pkg::RES_NUM_BITS-1:0] res_num_q;
  logic [rau_pkg::RES_DEN_BITS-1:0] res_den_q;
  rau_pkg::status_e                 status_q;

  assign res_neg = (nm_q != '0) && (num_neg_q != den_neg_q);
  assign nm_x    = XN'(nm_q);
  assign num_val = res_neg ? (~nm_x + 1'b1) : nm_x;
  assign dm_x    = XD'(dm_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      status_q <= err_q;
      if (err_q != rau_pkg::STATUS_OK) begin
        res_num_q <= '0;
        res_den_q <= rau_pkg::RES_DEN_BITS'(1);
      end else begin
        res_num_q <= num_val[rau_pkg::RES_NUM_BITS-1:0];
        res_den_q <= dm_x[rau_pkg::RES_DEN_BITS-1:0];
      end
    end
  end

  assign sts_o.err      = err_q;
  assign sts_o.gcd_done = (u_q == '0);
  assign sts_o.div_done = div_done;

  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign status_o  = status_q;

endmodule

[design/rau_ctrl.sv]
module rau_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  rau_pkg::sts_t sts_i,
  output rau_pkg::ctl_t ctl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_A,
    S_MUL_B,
    S_MUL_C,
    S_SUM,
    S_FIX,
    S_GINIT,
    S_GCD,
    S_GLOAD,
    S_DIVN,
    S_WAITN,
    S_DIVD,
    S_WAITD,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    ctl_o.mul_sel = rau_pkg::MUL_T1;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d       = S_MUL_A;
        end
      end
      S_MUL_A: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = rau_pkg::MUL_T1;
        // bad operands skip straight to the result
        state_d = (sts_i.err != rau_pkg::STATUS_OK) ? S_FINISH : S_MUL_B;
      end
      S_MUL_B: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = rau_pkg::MUL_T2;
        state_d       = S_MUL_C;
      end
      S_MUL_C: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = rau_pkg::MUL_DEN;
        state_d       = S_SUM;
      end
      S_SUM: begin
        ctl_o.sum = 1'b1;
        state_d   = S_FIX;
      end
      S_FIX: begin
        ctl_o.fix = 1'b1;
        state_d   = S_GINIT;
      end
      S_GINIT: begin
        ctl_o.gcd_init = 1'b1;
        state_d        = S_GCD;
      end
      S_GCD: begin
        if (sts_i.gcd_done) begin
          state_d = S_GLOAD;
        end else begin
          ctl_o.gcd_step = 1'b1;
        end
      end
      S_GLOAD: begin
        ctl_o.g_load = 1'b1;
        state_d      = S_DIVN;
      end
      S_DIVN: begin
        ctl_o.div_start = 1'b1;
        state_d         = S_WAITN;
      end
      S_WAITN: begin
        if (sts_i.div_done) begin
          ctl_o.q_load = 1'b1;
          state_d      = S_DIVD;
        end
      end
      S_DIVD: begin
        ctl_o.div_start = 1'b1;
        ctl_o.div_den   = 1'b1;
        state_d         = S_WAITD;
      end
      S_WAITD: begin
        ctl_o.div_den = 1'b1;
        if (sts_i.div_done) begin
          ctl_o.q_load = 1'b1;
          state_d      = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctl_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[design/rational_arithmetic_unit.sv]
// Rational arithmetic unit: add, subtract, multiply or divide two signed
// fractions and return the result reduced to lowest terms.
// Input channel in_valid_i/in_ready_o carries one beat: cmd_i and the two
// fractions a_num_i/a_den_i, b_num_i/b_den_i (OPERAND_BITS each, signed).
// Output channel out_valid_o/out_ready_i carries res_num_o (signed), a
// positive res_den_o and status_o (ok, zero denominator, divide by zero).
// One item is worked at a time. Three cross products come from one shared
// multiplier, the gcd is found by a binary gcd loop (one shift or subtract
// per cycle on W-bit magnitudes, W = 2*OPERAND_BITS+1), and both terms are
// divided by it in turn on one restoring divider. An error beat skips
// straight to the result. The result sits in an output register; the next
// beat is accepted while it waits, and a stalled receiver holds the unit
// only when the next result is ready to load. Reset clears the controller
// and drops out_valid_o.
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [rau_pkg::CMD_BITS-1:0]            cmd_i,
  input  logic signed [OPERAND_BITS-1:0]          a_num_i,
  input  logic signed [OPERAND_BITS-1:0]          a_den_i,
  input  logic signed [OPERAND_BITS-1:0]          b_num_i,
  input  logic signed [OPERAND_BITS-1:0]          b_den_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [rau_pkg::RES_NUM_BITS-1:0] res_num_o,
  output logic [rau_pkg::RES_DEN_BITS-1:0]        res_den_o,
  output logic [rau_pkg::STATUS_BITS-1:0]         status_o
);

  rau_pkg::ctl_t ctl;
  rau_pkg::sts_t sts;

  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  rau_dp #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .cmd_i     (cmd_i),
    .a_num_i   (a_num_i),
    .a_den_i   (a_den_i),
    .b_num_i   (b_num_i),
    .b_den_i   (b_den_i),
    .sts_o     (sts),
    .res_num_o (res_num_o),
    .res_den_o (res_den_o),
    .status_o  (status_o)
  );

endmodule
